[src/cidt_pkg.sv]
// shared types and constants for the compacting id record table
`timescale 1ns / 1ps
package cidt_pkg;

   localparam int ID_W    = 31;
   localparam int DAY_W   = 5;
   localparam int MON_W   = 4;
   localparam int YEAR_W  = 14;
   localparam int CAL_W   = 2;
   localparam int KIND_W  = 2;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 8;

   typedef logic [ID_W-1:0] id_type;

   localparam id_type ID_FIRST = id_type'(1);
   localparam id_type ID_MAX   = {ID_W{1'b1}};

   typedef struct packed {
      id_type             id;
      logic [DAY_W-1:0]   day;
      logic [MON_W-1:0]   month;
      logic [YEAR_W-1:0]  year;
      logic [CAL_W-1:0]   calendar;
   } entry_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD    = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_FIND   = 2'd2
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_DONE = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_MISS = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic      capture;
      logic      add_en;
      logic      del_en;
      id_type    key;
      entry_type rec;
   } cell_ctl_type;

endpackage

[src/cidt_if.sv]
// request and response channel interfaces
`timescale 1ns / 1ps
interface cidt_req_if;
   import cidt_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [ID_W-1:0]   key_id;
   logic [DAY_W-1:0]  rec_day;
   logic [MON_W-1:0]  rec_month;
   logic [YEAR_W-1:0] rec_year;
   logic [CAL_W-1:0]  rec_calendar;

   modport source (output valid, kind, key_id, rec_day, rec_month, rec_year, rec_calendar,
                   input ready);
   modport sink (input valid, kind, key_id, rec_day, rec_month, rec_year, rec_calendar,
                 output ready);
endinterface

interface cidt_rsp_if;
   import cidt_pkg::*;

   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [ID_W-1:0]    out_id;
   logic [DAY_W-1:0]   out_day;
   logic [MON_W-1:0]   out_month;
   logic [YEAR_W-1:0]  out_year;
   logic [CAL_W-1:0]   out_calendar;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, status, out_id, out_day, out_month, out_year, out_calendar,
                   entry_count, input ready);
   modport sink (input valid, status, out_id, out_day, out_month, out_year, out_calendar,
                 entry_count, output ready);
endinterface

[src/cidt_cell.sv]
// one table slot: holds a record, compares its id and shifts down on delete
`timescale 1ns / 1ps
module cidt_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  cidt_pkg::cell_ctl_type ctl,
   input  cidt_pkg::entry_type   up_entry,
   input  logic                  up_valid,
   input  logic                  below_valid,
   input  logic                  shift_sel,
   output cidt_pkg::entry_type   entry,
   output logic                  valid,
   output logic                  match
);
   import cidt_pkg::*;

   entry_type entry_ff;
   logic      valid_ff;
   logic      match_ff;
   logic      take_add;
   logic      take_shift;

   // valid slots stay contiguous from slot zero, so the first empty slot takes an add
   assign take_add   = ctl.add_en && below_valid && !valid_ff;
   assign take_shift = ctl.del_en && shift_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         if (take_add) begin
            valid_ff <= 1'b1;
         end else if (take_shift) begin
            valid_ff <= up_valid;
         end
         if (ctl.capture) begin
            match_ff <= valid_ff && (entry_ff.id == ctl.key);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_add) begin
         entry_ff <= ctl.rec;
      end else if (take_shift) begin
         entry_ff <= up_entry;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;
   assign match = match_ff;

endmodule

[src/compacting_id_record_table_core.sv]
// Compacting id record table: TABLE_DEPTH slots in a row of cells, each slot holding one
// date record and its id. A request is accepted in the idle state: all cells compare
// their id against the key in parallel and latch a match bit. In the exec state, the
// lowest matching slot is picked through a log-depth prefix OR over the match bits, a
// delete shifts every slot above it down by one in a single step, an add lands in the
// first empty slot, and the response register is loaded. If the previous response is
// still waiting, the exec state stretches until it is taken. The next request is taken
// once the response register is loaded. Reset empties the table at once through per-slot
// valid bits; no clearing sweep is needed.
`timescale 1ns / 1ps
module compacting_id_record_table_core #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic          clock,
   input  logic          reset,
   cidt_req_if.sink      req,
   cidt_rsp_if.source    rsp
);
   import cidt_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int LVL   = $clog2(TABLE_DEPTH);

   state_type state_ff, state_in;
   logic      accept;
   logic      commit;

   logic [KIND_W-1:0] kind_ff;
   logic [DAY_W-1:0]  day_ff;
   logic [MON_W-1:0]  month_ff;
   logic [YEAR_W-1:0] year_ff;
   logic [CAL_W-1:0]  cal_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   id_type           next_id_ff, next_id_in;
   logic             full;

   cell_ctl_type     ctl;
   entry_type        cell_entry [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] cell_valid;
   logic [TABLE_DEPTH-1:0] cell_match;
   logic [TABLE_DEPTH-1:0] pfx [LVL+1];
   logic [TABLE_DEPTH-1:0] shift_sel;
   logic [TABLE_DEPTH-1:0] first_hit;
   logic             any_hit;
   entry_type        hit_entry;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   entry_type          rsp_entry_ff, rsp_entry_in;
   logic [COUNT_W-1:0] rsp_count_ff;

   // controller
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req.ready = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp.ready) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign accept = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req.kind;
         day_ff   <= req.rec_day;
         month_ff <= req.rec_month;
         year_ff  <= req.rec_year;
         cal_ff   <= req.rec_calendar;
      end
   end

   assign full = (count_ff == CNT_W'(TABLE_DEPTH));

   always_comb begin
      ctl.capture      = accept;
      ctl.key          = req.key_id;
      ctl.add_en       = commit && (kind_ff == KIND_ADD) && !full;
      ctl.del_en       = commit && (kind_ff == KIND_DELETE);
      ctl.rec.id       = next_id_ff;
      ctl.rec.day      = day_ff;
      ctl.rec.month    = month_ff;
      ctl.rec.year     = year_ff;
      ctl.rec.calendar = cal_ff;
   end

   // row of cells
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_type up_entry;
      logic      up_valid;
      logic      below_valid;

      if (i == TABLE_DEPTH - 1) begin : g_top
         assign up_entry = '0;
         assign up_valid = 1'b0;
      end else begin : g_mid
         assign up_entry = cell_entry[i+1];
         assign up_valid = cell_valid[i+1];
      end

      if (i == 0) begin : g_bottom
         assign below_valid = 1'b1;
      end else begin : g_upper
         assign below_valid = cell_valid[i-1];
      end

      cidt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .up_entry    (up_entry),
         .up_valid    (up_valid),
         .below_valid (below_valid),
         .shift_sel   (shift_sel[i]),
         .entry       (cell_entry[i]),
         .valid       (cell_valid[i]),
         .match       (cell_match[i])
      );
   end

   // prefix or of match bits, log-depth
   always_comb begin
      pfx[0] = cell_match;
      for (int l = 0; l < LVL; l++) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            pfx[l+1][i] = pfx[l][i];
            if (i >= (1 << l)) begin
               pfx[l+1][i] = pfx[l][i] | pfx[l][i - (1 << l)];
            end
         end
      end
   end

   assign shift_sel = pfx[LVL];
   assign first_hit = cell_match & ~(shift_sel << 1);
   assign any_hit   = |cell_match;

   always_comb begin
      hit_entry = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit_entry = hit_entry | ({$bits(entry_type){first_hit[i]}} & cell_entry[i]);
      end
   end

   // counters and response
   always_comb begin
      count_in      = count_ff;
      next_id_in    = next_id_ff;
      rsp_status_in = STATUS_DONE;
      rsp_entry_in  = '0;
      unique case (kind_ff)
         KIND_ADD: begin
            if (full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               rsp_entry_in.id = next_id_ff;
               count_in        = count_ff + CNT_W'(1);
               next_id_in      = (next_id_ff == ID_MAX) ? ID_FIRST : next_id_ff + ID_FIRST;
            end
         end
         KIND_DELETE: begin
            if (any_hit) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               rsp_status_in = STATUS_MISS;
            end
         end
         KIND_FIND: begin
            if (any_hit) begin
               rsp_entry_in = hit_entry;
            end else begin
               rsp_status_in = STATUS_MISS;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         next_id_ff   <= ID_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            count_ff   <= count_in;
            next_id_ff <= next_id_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_entry_ff  <= rsp_entry_in;
         rsp_count_ff  <= COUNT_W'(count_in);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.out_id       = rsp_entry_ff.id;
   assign rsp.out_day      = rsp_entry_ff.day;
   assign rsp.out_month    = rsp_entry_ff.month;
   assign rsp.out_year     = rsp_entry_ff.year;
   assign rsp.out_calendar = rsp_entry_ff.calendar;
   assign rsp.entry_count  = rsp_count_ff;

endmodule

[src/cidt_checker.sv]
// port-level assertions for the record table, bound to the top level
`timescale 1ns / 1ps
module cidt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [cidt_pkg::STAT_W-1:0] rsp_status,
   input logic [cidt_pkg::ID_W-1:0]   rsp_out_id,
   input logic [cidt_pkg::DAY_W-1:0]  rsp_out_day,
   input logic [cidt_pkg::YEAR_W-1:0] rsp_out_year
);
   import cidt_pkg::*;

   // response held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one request in flight: ready drops right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in flight");

   // a full or missed request carries no record
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL || rsp_status == STATUS_MISS) |->
         rsp_out_id == '0 && rsp_out_day == '0 && rsp_out_year == '0)
      else $error("failed request returned record data");

endmodule

bind compacting_id_record_table_core cidt_checker u_cidt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_status   (rsp.status),
   .rsp_out_id   (rsp.out_id),
   .rsp_out_day  (rsp.out_day),
   .rsp_out_year (rsp.out_year)
);
